[hdl/hau_pkg.sv]
// hau_pkg: shared types and constants for the highest average unit allocator
// field widths, request codes and the controller state encoding
// no dependencies
package hau_pkg;

  localparam int unsigned GROUP_W  = 4;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned CFG_W    = 5;
  localparam int unsigned ENTRY_W  = WEIGHT_W + COUNT_W;
  localparam int unsigned IN_W     = 24;
  localparam int unsigned OUT_W    = 24;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_GRANT = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_SWEEP,
    S_DRAIN,
    S_GRANT_WR,
    S_RESP
  } state_t;

endpackage

[hdl/highest_average_unit_allocator_top.sv]
// highest_average_unit_allocator_top: highest averages unit allocator
// one entry memory of {weight, count} per group, swept by one comparator
// depends on hau_pkg
//
// usage
//   s_* channel takes requests: s_tuser holds the request kind (load, grant,
//   read), s_tdata holds the group index and the weight
//   m_* channel returns {group, count} for grant and read requests; loads,
//   unused request kinds and out-of-range reads return nothing
//   cfg_wen/cfg_wdata set the number of groups that take part in grants;
//   write it only while the block is idle
// timing
//   one request is worked on at a time; s_tready is high only when idle
//   load: the entry is written at the accepting edge
//   read: the entry is read in S_RD_ISSUE, its count captured in S_RD_WAIT
//   grant: the entry memory is read once per active group through its
//   single read port, one candidate a cycle
// reset
//   rst clears the per-entry valid bits, so every group reads as weight 0
//   and count 1 with no clearing pass; active groups returns to 1
// stall
//   a result waits in the output register; the controller holds in its
//   response state until m_tready frees the register
module highest_average_unit_allocator_top #(
  parameter int unsigned MAX_GROUPS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration: active_groups
  input  logic                        cfg_wen,
  input  logic [hau_pkg::CFG_W-1:0]   cfg_wdata,
  // request channel
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [hau_pkg::IN_W-1:0]    s_tdata,   // group_index[3:0], weight[19:4], zero pad
  input  logic [1:0]                  s_tuser,   // req_type[1:0]
  // result channel
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [hau_pkg::OUT_W-1:0]   m_tdata    // result_group[3:0], result_count[19:4], zero pad
);

  import hau_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_GROUPS);

  // entry memory and per-entry valid bits (invalid entry reads as reset value)
  logic [ENTRY_W-1:0]    mem [MAX_GROUPS];
  logic [MAX_GROUPS-1:0] vld;

  state_t state, state_next;

  logic [CFG_W-1:0]  active_groups;

  // request capture
  logic [IDX_W-1:0]  req_idx;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  rd_idx;

  // memory ports
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [ENTRY_W-1:0] rd_q;
  logic              rd_hit;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ENTRY_W-1:0] wr_data;

  // comparator pipeline
  logic              cand_vld;
  logic [IDX_W-1:0]  cand_idx;
  logic [WEIGHT_W-1:0] ent_w;
  logic [COUNT_W-1:0]  ent_c;
  logic [IDX_W-1:0]  best_idx;
  logic [WEIGHT_W-1:0] best_w;
  logic [COUNT_W-1:0]  best_c;
  logic [COUNT_W:0]  best_c1;
  logic [COUNT_W:0]  ent_c1;
  logic [WEIGHT_W+COUNT_W:0] lhs, rhs;
  logic              take;
  logic [COUNT_W-1:0] grant_c;

  // pending result
  logic [GROUP_W-1:0] res_group;
  logic [COUNT_W-1:0] res_count;

  // input decode
  logic               in_xfer;
  logic [GROUP_W-1:0] in_group;
  logic [WEIGHT_W-1:0] in_weight;
  logic               in_range;
  logic [IDX_W-1:0]   in_addr;
  logic [IDX_W-1:0]   last_calc;
  logic               out_free;

  assign in_group  = s_tdata[GROUP_W-1:0];
  assign in_weight = s_tdata[GROUP_W+WEIGHT_W-1:GROUP_W];
  assign in_range  = (int'(in_group) < int'(MAX_GROUPS));
  assign in_addr   = IDX_W'(in_group);
  assign in_xfer   = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // effective group count clamped to 1..MAX_GROUPS, kept as last index
  always_comb begin
    if (active_groups == '0) begin
      last_calc = '0;
    end else if (int'(active_groups) > int'(MAX_GROUPS)) begin
      last_calc = IDX_W'(MAX_GROUPS - 1);
    end else begin
      last_calc = IDX_W'(active_groups - CFG_W'(1));
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      active_groups <= CFG_W'(1);
    end else if (cfg_wen) begin
      active_groups <= cfg_wdata;
    end
  end

  // entry as read: never-written entries look like weight 0, count 1
  assign ent_w   = rd_hit ? rd_q[ENTRY_W-1:COUNT_W] : '0;
  assign ent_c   = rd_hit ? rd_q[COUNT_W-1:0] : COUNT_RESET;
  assign ent_c1  = {1'b0, ent_c} + (COUNT_W+1)'(1);
  assign best_c1 = {1'b0, best_c} + (COUNT_W+1)'(1);

  // exact cross-products: candidate wins only when strictly larger
  assign lhs  = (WEIGHT_W+COUNT_W+1)'(ent_w)  * (WEIGHT_W+COUNT_W+1)'(best_c1);
  assign rhs  = (WEIGHT_W+COUNT_W+1)'(best_w) * (WEIGHT_W+COUNT_W+1)'(ent_c1);
  assign take = cand_vld && ((cand_idx == '0) || (lhs > rhs));

  // saturating increment of the winner
  assign grant_c = (best_c == COUNT_MAX) ? best_c : best_c + COUNT_W'(1);

  // next state and strobes
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = rd_idx;
    wr_en      = 1'b0;
    wr_addr    = best_idx;
    wr_data    = {best_w, grant_c};
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (s_tuser)
            REQ_LOAD: begin
              wr_en   = in_range;
              wr_addr = in_addr;
              wr_data = {in_weight, COUNT_RESET};
            end
            REQ_GRANT: state_next = S_SWEEP;
            REQ_READ: begin
              if (in_range) begin
                state_next = S_RD_ISSUE;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RD_ISSUE: begin
        rd_en      = 1'b1;
        rd_addr    = req_idx;
        state_next = S_RD_WAIT;
      end
      S_RD_WAIT: state_next = S_RESP;
      S_SWEEP: begin
        rd_en = 1'b1;
        if (rd_idx == last_idx) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_GRANT_WR;
      S_GRANT_WR: begin
        wr_en      = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= vld[rd_addr];
      end
    end
  end

  // sweep control and candidate tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      cand_vld <= 1'b0;
    end else begin
      cand_vld <= (state == S_SWEEP);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_idx  <= in_addr;
      last_idx <= last_calc;
      rd_idx   <= '0;
    end else if (state == S_SWEEP) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
    cand_idx <= rd_idx;
    if (take) begin
      best_idx <= cand_idx;
      best_w   <= ent_w;
      best_c   <= ent_c;
    end
    if (state == S_RD_WAIT) begin
      res_group <= GROUP_W'(req_idx);
      res_count <= ent_c;
    end else if (state == S_GRANT_WR) begin
      res_group <= GROUP_W'(best_idx);
      res_count <= grant_c;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_RESP && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && out_free) begin
      m_tdata <= {(OUT_W-GROUP_W-COUNT_W)'(0), res_count, res_group};
    end
  end

`ifndef SYNTHESIS
  // memory writes only come from an idle load or the grant write-back
  a_write_source: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_IDLE && s_tvalid && s_tuser == REQ_LOAD) ||
              state == S_GRANT_WR)
    else $error("unexpected entry write");

  // the winner always lies inside the active range
  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_GRANT_WR |-> best_idx <= last_idx)
    else $error("granted group outside active range");

  // a written entry is marked valid on the next cycle
  a_valid_after_write: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> vld[$past(wr_addr)])
    else $error("entry valid bit not set after write");

  // counts start at one and never wrap to zero
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[GROUP_W+COUNT_W-1:GROUP_W] != '0)
    else $error("zero count returned");

  // no request is taken in the sweep, drain or response states
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP || state == S_DRAIN || state == S_RESP) |-> !s_tready)
    else $error("request taken while busy");
`endif

endmodule

[bench/highest_average_unit_allocator_top_tb.sv]
// highest_average_unit_allocator_top_tb: self-checking bench for the allocator top level
// tracks weights and counts in a local copy and checks each grant or read reply in order
// depends on hau_pkg and highest_average_unit_allocator_top
module highest_average_unit_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import hau_pkg::*;

  localparam int unsigned MAX_GROUPS    = 16;
  localparam int unsigned CLK_PERIOD    = 8;
  // a grant sweeps every active group, so let that much time pass before a config write
  localparam int unsigned SETTLE_CYCLES = MAX_GROUPS + 8;
  // long receiver hold-off that backs the block up into its request port
  localparam int unsigned HOLD_CYCLES   = 300;
  // cycles with no transfer on either side before the run is called hung
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned REPORT_LIMIT  = 10;
  // request code the block has no use for
  localparam logic [1:0]  REQ_UNUSED    = 2'd3;

  typedef struct packed {
    logic [GROUP_W-1:0] grp;
    logic [COUNT_W-1:0] units;
  } count_reply_t;

  logic               clk;
  logic               rst;
  logic               cfg_wen;
  logic [CFG_W-1:0]   cfg_wdata;
  logic               s_tvalid;
  logic               s_tready;
  logic [IN_W-1:0]    s_tdata;   // group_index[3:0], weight[19:4], zero pad
  logic [1:0]         s_tuser;   // req_type[1:0]
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_W-1:0]   m_tdata;   // result_group[3:0], result_count[19:4], zero pad

  // local copy of the block state, advanced at every accepted request
  logic [WEIGHT_W-1:0] shadow_weight [MAX_GROUPS];
  logic [COUNT_W-1:0]  shadow_count  [MAX_GROUPS];
  logic [CFG_W-1:0]    shadow_active;

  // replies the block still owes, oldest first
  count_reply_t awaited_counts[$];

  int unsigned mismatch_count;
  bit          idle_en;       // random gaps on both sides
  bit          hold_result;   // asks the result side for one long hold-off

  highest_average_unit_allocator_top #(
    .MAX_GROUPS(MAX_GROUPS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // allocation predictor
  // ---------------------------------------------------------------------------

  // work out what one accepted request does to the state and what reply it owes
  function automatic void predict_allocation(input logic [1:0] kind,
                                             input logic [GROUP_W-1:0] grp,
                                             input logic [WEIGHT_W-1:0] wt);
    int unsigned     span;
    int unsigned     best;
    longint unsigned lhs;
    longint unsigned rhs;
    count_reply_t    reply;
    case (kind)
      REQ_LOAD: begin
        // a load touches the entry even outside the active range
        if (grp < MAX_GROUPS) begin
          shadow_weight[grp] = wt;
          shadow_count[grp]  = COUNT_RESET;
        end
      end
      REQ_GRANT: begin
        span = int'(shadow_active);
        if (span < 1) span = 1;
        if (span > MAX_GROUPS) span = MAX_GROUPS;
        best = 0;
        // exact cross-products; a later group wins only when strictly larger
        for (int unsigned g = 1; g < span; g++) begin
          lhs = 64'(shadow_weight[g]) * (64'(shadow_count[best]) + 64'd1);
          rhs = 64'(shadow_weight[best]) * (64'(shadow_count[g]) + 64'd1);
          if (lhs > rhs) best = g;
        end
        // count saturates, the grant is still reported
        if (shadow_count[best] != COUNT_MAX) shadow_count[best] = shadow_count[best] + 1'b1;
        reply.grp   = GROUP_W'(best);
        reply.units = shadow_count[best];
        awaited_counts.push_back(reply);
      end
      REQ_READ: begin
        if (grp < MAX_GROUPS) begin
          reply.grp   = grp;
          reply.units = shadow_count[grp];
          awaited_counts.push_back(reply);
        end
      end
      default: begin
        // unused request code: nothing happens
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offer one request and hold it until the block takes it; valid stays high
  // after the transfer so a back-to-back request needs no second assignment
  task automatic send_request(input logic [1:0] kind, input logic [GROUP_W-1:0] grp,
                              input logic [WEIGHT_W-1:0] wt);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(IN_W - GROUP_W - WEIGHT_W){1'b0}}, wt, grp};
    do @(posedge clk); while (!s_tready);
    predict_allocation(kind, grp, wt);
  endtask

  // drop valid, let every owed reply arrive and the block settle
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (awaited_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // config writes only happen with the block idle
  task automatic set_active_groups(input logic [CFG_W-1:0] setting);
    wait_drained();
    cfg_wen   <= 1'b1;
    cfg_wdata <= setting;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    shadow_active = setting;
  endtask

  // extremes and small values are favored so ties and near ties come up often
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return WEIGHT_W'($urandom_range(1, 8));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  // mostly grants, with loads and reads aimed at the active groups and some noise
  task automatic send_random_item(input int unsigned span);
    int unsigned        roll;
    logic [GROUP_W-1:0] grp;
    roll = $urandom_range(0, 99);
    grp  = ($urandom_range(0, 3) == 0) ? GROUP_W'($urandom)
                                        : GROUP_W'($urandom_range(0, span - 1));
    if (roll < 25)      send_request(REQ_LOAD, grp, pick_weight());
    else if (roll < 80) send_request(REQ_GRANT, GROUP_W'($urandom), WEIGHT_W'($urandom));
    else if (roll < 95) send_request(REQ_READ, grp, WEIGHT_W'($urandom));
    else                send_request(REQ_UNUSED, GROUP_W'($urandom), WEIGHT_W'($urandom));
  endtask

  // one setting: load every active group, then a random mix
  task automatic run_phase(input logic [CFG_W-1:0] setting, input int unsigned items);
    int unsigned span;
    set_active_groups(setting);
    span = (setting == 0) ? 1 : (int'(setting) > MAX_GROUPS) ? MAX_GROUPS : int'(setting);
    for (int unsigned g = 0; g < span; g++) send_request(REQ_LOAD, GROUP_W'(g), pick_weight());
    repeat (items) send_random_item(span);
  endtask

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  // random ready gaps, plus one long hold-off when asked, counted here
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    m_tready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_result) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_result = 1'b0;
        m_tready <= 1'b1;
      end else begin
        if (stall_left == 0 && idle_en && $urandom_range(0, 7) == 0)
          stall_left = $urandom_range(1, 5);
        if (stall_left > 0) begin
          m_tready <= 1'b0;
          stall_left--;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  // compare every reply transfer with the oldest owed reply
  count_reply_t head;
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_counts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected reply group %0d count %0d", $realtime,
                   m_tdata[GROUP_W-1:0], m_tdata[GROUP_W+COUNT_W-1:GROUP_W]);
      end else begin
        head = awaited_counts.pop_front();
        if (m_tdata[GROUP_W-1:0] !== head.grp ||
            m_tdata[GROUP_W+COUNT_W-1:GROUP_W] !== head.units) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: reply mismatch, expected group %0d count %0d, got group %0d count %0d",
                     $realtime, head.grp, head.units,
                     m_tdata[GROUP_W-1:0], m_tdata[GROUP_W+COUNT_W-1:GROUP_W]);
        end
      end
    end
  end

  // hang detector: any transfer on either side restarts the count
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset values, all-zero weights, ties, unused code, active count clamping
  task automatic test_directed();
    send_request(REQ_READ, 4'd0, 16'h0000);
    send_request(REQ_READ, 4'd15, 16'hFFFF);
    // one active group, all weights zero
    send_request(REQ_GRANT, 4'd0, 16'h0000);
    set_active_groups(CFG_W'(16));
    // every product zero, group 0 must win
    send_request(REQ_GRANT, 4'd9, 16'h1234);
    send_request(REQ_LOAD, 4'd0, 16'h0000);
    send_request(REQ_LOAD, 4'd15, 16'hFFFF);
    send_request(REQ_LOAD, 4'd7, 16'hFFFF);
    // equal quotients on 7 and 15: lowest index first
    send_request(REQ_GRANT, 4'd0, 16'h0000);
    send_request(REQ_GRANT, 4'd0, 16'h0000);
    send_request(REQ_READ, 4'd7, 16'h0000);
    send_request(REQ_UNUSED, 4'd15, 16'hFFFF);
    send_request(REQ_LOAD, 4'd5, 16'hAAAA);
    send_request(REQ_LOAD, 4'd10, 16'h5555);
    // group 5 ties with 7 and 15 on the exact cross-product
    send_request(REQ_GRANT, 4'd15, 16'hFFFF);
    send_request(REQ_READ, 4'd5, 16'h0000);
    // zero active groups acts as one
    set_active_groups(CFG_W'(0));
    send_request(REQ_GRANT, 4'd0, 16'h0000);
    // above the group count acts as all groups
    set_active_groups(CFG_W'(31));
    send_request(REQ_GRANT, 4'd0, 16'h0000);
    send_request(REQ_READ, 4'd15, 16'h0000);
  endtask

  // several settings, extremes included, random traffic in each
  task automatic test_config_sweep();
    logic [CFG_W-1:0] settings[8];
    settings = '{CFG_W'(16), CFG_W'(2), CFG_W'(1), CFG_W'(0),
                 CFG_W'(31), CFG_W'(17), CFG_W'(9), CFG_W'(5)};
    foreach (settings[i]) run_phase(settings[i], 80);
  endtask

  // result side holds off while requests keep coming, so the block backs up
  task automatic test_backpressure();
    set_active_groups(CFG_W'(16));
    hold_result = 1'b1;
    repeat (40) send_random_item(MAX_GROUPS);
  endtask

  // closing stretch with both sides running flat out
  task automatic test_quiet_tail();
    idle_en = 1'b0;
    run_phase(CFG_W'(16), 100);
  endtask

  initial begin
    idle_en        = 1'b1;
    hold_result    = 1'b0;
    mismatch_count = 0;
    shadow_active  = CFG_W'(1);
    for (int unsigned g = 0; g < MAX_GROUPS; g++) begin
      shadow_weight[g] = '0;
      shadow_count[g]  = COUNT_RESET;
    end
    rst       <= 1'b1;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_config_sweep();
    test_backpressure();
    test_quiet_tail();
    wait_drained();

    if (mismatch_count == 0 && awaited_counts.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
